/* rtl/core/ncr_pkg.sv */
// Shared types and constants for the numeric character reference decoder.
// No dependencies.
package ncr_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned AccW   = 32;
    localparam int unsigned CountW = 3;
    localparam int unsigned DigitW = 4;

    localparam logic [ByteW-1:0] ChSemi  = 8'h3B;  // ';'
    localparam logic [ByteW-1:0] ChLowX  = 8'h78;  // 'x'
    localparam logic [ByteW-1:0] ChZero  = 8'h30;  // '0'
    localparam logic [ByteW-1:0] ChNine  = 8'h39;  // '9'
    localparam logic [ByteW-1:0] ChUpA   = 8'h41;  // 'A'
    localparam logic [ByteW-1:0] ChUpF   = 8'h46;  // 'F'
    localparam logic [ByteW-1:0] ChLowA  = 8'h61;  // 'a'
    localparam logic [ByteW-1:0] ChLowF  = 8'h66;  // 'f'

    typedef enum logic [1:0] {
        ST_CONTINUE = 2'd0,
        ST_DEADEND  = 2'd1,
        ST_DONE     = 2'd2
    } ncr_status_t;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_DEC  = 3'b010,
        MODE_HEX  = 3'b100
    } ncr_mode_t;

    // Character class of one input byte.
    typedef struct packed {
        logic              is_semi;
        logic              is_x;
        logic              dec_ok;   // '0'..'9'
        logic              hex_ok;   // '0'..'9', 'A'..'F', 'a'..'f'
        logic [DigitW-1:0] digit;    // value when dec_ok or hex_ok
    } ncr_class_t;

    // One result item.
    typedef struct packed {
        ncr_status_t       status;
        logic [AccW-1:0]   code_point;
        logic [CountW-1:0] byte_count;
    } ncr_result_t;

endpackage

/* rtl/core/ncr_classify.sv */
// Byte classifier: semicolon, 'x', decimal and hex digit decode.
// Depends on ncr_pkg.
module ncr_classify
    import ncr_pkg::*;
(
    input  logic [ByteW-1:0] in_byte,
    output ncr_class_t       cls
);

    logic is_num;
    logic is_upper;
    logic is_lower;

    always_comb begin
        is_num   = (in_byte >= ChZero) && (in_byte <= ChNine);
        is_upper = (in_byte >= ChUpA)  && (in_byte <= ChUpF);
        is_lower = (in_byte >= ChLowA) && (in_byte <= ChLowF);

        cls.is_semi = (in_byte == ChSemi);
        cls.is_x    = (in_byte == ChLowX);
        cls.dec_ok  = is_num;
        cls.hex_ok  = is_num || is_upper || is_lower;

        // Low nibble gives the digit; letters are offset by 9.
        if (is_num) begin
            cls.digit = in_byte[DigitW-1:0];
        end else if (is_upper || is_lower) begin
            cls.digit = in_byte[DigitW-1:0] + DigitW'(9);
        end else begin
            cls.digit = '0;
        end
    end

endmodule

/* rtl/core/ncr_parse.sv */
// Parse state (mode and accumulator) and the per-byte result logic.
// Depends on ncr_pkg; takes the class from ncr_classify.
module ncr_parse
    import ncr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  ncr_class_t  cls,
    output ncr_result_t result
);

    ncr_mode_t       mode_reg, mode_next;
    logic [AccW-1:0] acc_reg, acc_next;
    logic [AccW-1:0] acc_dec;
    logic [AccW-1:0] acc_hex;
    logic [AccW-1:0] digit_ext;

    always_comb begin
        digit_ext = AccW'(cls.digit);
        // x10 as x8 + x2, x16 as a shift; both wrap at the word width.
        acc_dec   = (acc_reg << 3) + (acc_reg << 1) + digit_ext;
        acc_hex   = (acc_reg << 4) + digit_ext;
    end

    function automatic logic [CountW-1:0] count_bytes(input logic [AccW-1:0] v);
        logic [CountW-1:0] n;
        priority if (v[31:24] != '0) n = CountW'(4);
        else if (v[23:16] != '0)     n = CountW'(3);
        else if (v[15:8]  != '0)     n = CountW'(2);
        else if (v[7:0]   != '0)     n = CountW'(1);
        else                         n = '0;
        return n;
    endfunction

    always_comb begin
        mode_next         = mode_reg;
        acc_next          = acc_reg;
        result.status     = ST_CONTINUE;
        result.code_point = '0;
        result.byte_count = '0;

        unique case (mode_reg)
            MODE_DEC, MODE_HEX: begin
                if (cls.is_semi) begin
                    result.status     = ST_DONE;
                    result.code_point = acc_reg;
                    result.byte_count = count_bytes(acc_reg);
                    mode_next         = MODE_IDLE;
                end else if (mode_reg == MODE_HEX && cls.hex_ok) begin
                    acc_next = acc_hex;
                end else if (mode_reg == MODE_DEC && cls.dec_ok) begin
                    acc_next = acc_dec;
                end else begin
                    result.status = ST_DEADEND;
                    mode_next     = MODE_IDLE;
                end
            end
            default: begin
                // Idle.
                if (cls.is_x) begin
                    mode_next = MODE_HEX;
                    acc_next  = '0;
                end else if (cls.dec_ok) begin
                    mode_next = MODE_DEC;
                    acc_next  = digit_ext;
                end else begin
                    result.status = ST_DEADEND;
                    mode_next     = MODE_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
        end else if (advance) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

/* rtl/core/numeric_char_ref_decoder.sv */
// Top level of the numeric character reference decoder: input register,
// parse logic, result register. Depends on ncr_pkg, ncr_classify, ncr_parse.
//
// Usage:
//   Feed the bytes that follow "&#" on the s_ channel, one byte per item.
//   Every byte yields exactly one item on the m_ channel:
//     status continue  - byte taken ('x' or a digit of the current base)
//     status dead end  - byte not valid here; parser back to idle
//     status complete  - ';' closed the reference; m_code_point holds the
//                        value (mod 2^32), m_byte_count its length in bytes
//                        after leading zero bytes are dropped (0 for zero).
//   code point and byte count read zero unless status is complete.
// Registers: the input register loads at the s_ accept edge and the result
//   register when the item advances, which sets m_valid. Throughput: 1 item
//   per cycle while m_ready stays high; the decimal/hex multiply-add is a
//   shift-add that fits between the two registers.
// Stall: when m_ready is low the result register holds and the input
//   register fills; s_ready drops once both are occupied. No item is lost.
// Reset (aresetn low, synchronous): both registers empty, parser idle,
//   accumulator zero.
module numeric_char_ref_decoder
    import ncr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [ByteW-1:0]  s_in_byte,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_result_status,
    output logic [AccW-1:0]   m_code_point,
    output logic [CountW-1:0] m_byte_count
);

    // Input register.
    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;

    // Result register.
    logic             out_valid_reg;
    ncr_result_t      out_reg;

    ncr_class_t  cls;
    ncr_result_t result;
    logic        advance;  // item moves from input to result register

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_in_byte;
        end
    end

    ncr_classify u_classify (
        .in_byte (in_byte_reg),
        .cls     (cls)
    );

    // Parser state commits only when the item advances.
    ncr_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .cls     (cls),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_result_status = out_reg.status;
    assign m_code_point    = out_reg.code_point;
    assign m_byte_count    = out_reg.byte_count;

endmodule

/* rtl/core/ncr_checker.sv */
// Port-level checks for numeric_char_ref_decoder, attached by bind.
// Depends on ncr_pkg.
module ncr_checker
    import ncr_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [1:0]        m_result_status,
    input logic [AccW-1:0]   m_code_point,
    input logic [CountW-1:0] m_byte_count
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_status)
            && $stable(m_code_point) && $stable(m_byte_count))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result_status == ST_CONTINUE)
            || (m_result_status == ST_DEADEND) || (m_result_status == ST_DONE))
        else $error("undefined status code");

    a_zero_unless_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_status != ST_DONE)
            |-> (m_code_point == '0) && (m_byte_count == '0))
        else $error("value reported without completion");

    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_status == ST_DONE)
            |-> (m_byte_count <= CountW'(4))
             && ((m_byte_count == '0) == (m_code_point == '0))
             && ((m_byte_count == CountW'(4)) == (m_code_point[31:24] != '0)))
        else $error("byte count does not match code point");

endmodule

bind numeric_char_ref_decoder ncr_checker u_ncr_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_result_status (m_result_status),
    .m_code_point    (m_code_point),
    .m_byte_count    (m_byte_count)
);

/* sim/tb_numeric_char_ref_decoder.sv */
`timescale 1ns / 1ps
// Self-checking bench for numeric_char_ref_decoder: byte stimulus, an item scoreboard
// with its own parser model, and randomized idle/stall phases. Depends on ncr_pkg and the RTL.
module tb_numeric_char_ref_decoder;
    import ncr_pkg::*;

    // Scoreboard: tracks parse mode and accumulator, queues one result per accepted byte.
    class ncr_scoreboard;
        ncr_result_t        due_q[$];
        ncr_mode_t          mode;
        logic [AccW-1:0]    acc;
        int unsigned        errors;
        int unsigned        n_bytes;
        int unsigned        n_done;
        int unsigned        n_dead;
        int unsigned        n_wide;   // completions that needed all four bytes

        function new();
            mode    = MODE_IDLE;
            acc     = '0;
            errors  = 0;
            n_bytes = 0;
            n_done  = 0;
            n_dead  = 0;
            n_wide  = 0;
        endfunction

        function int unsigned pending();
            return due_q.size();
        endfunction

        // Advance the parser by one accepted byte and queue the result it produces.
        function void note_byte(logic [ByteW-1:0] b);
            ncr_result_t       r;
            logic              hex_active;
            logic              is_digit;
            logic [DigitW-1:0] dval;

            r.status     = ST_CONTINUE;
            r.code_point = '0;
            r.byte_count = '0;
            hex_active   = (mode == MODE_HEX);
            is_digit     = 1'b1;
            dval         = '0;

            if (b >= ChZero && b <= ChNine)
                dval = DigitW'(b - ChZero);
            else if (hex_active && b >= ChUpA && b <= ChUpF)
                dval = DigitW'(b - ChUpA + 8'd10);
            else if (hex_active && b >= ChLowA && b <= ChLowF)
                dval = DigitW'(b - ChLowA + 8'd10);
            else
                is_digit = 1'b0;

            if (mode != MODE_IDLE) begin
                if (b == ChSemi) begin
                    r.status     = ST_DONE;
                    r.code_point = acc;
                    if (acc[31:24] != 0)      r.byte_count = 3'd4;
                    else if (acc[23:16] != 0) r.byte_count = 3'd3;
                    else if (acc[15:8] != 0)  r.byte_count = 3'd2;
                    else if (acc[7:0] != 0)   r.byte_count = 3'd1;
                    else                      r.byte_count = 3'd0;
                    mode = MODE_IDLE;
                end else if (!is_digit) begin
                    // dead end; accumulator is left as is, it is never seen
                    r.status = ST_DEADEND;
                    mode     = MODE_IDLE;
                end else begin
                    acc = acc * (hex_active ? 32'd16 : 32'd10) + AccW'(dval);
                end
            end else if (b == ChLowX) begin
                mode = MODE_HEX;
                acc  = '0;
            end else if (is_digit) begin
                mode = MODE_DEC;
                acc  = AccW'(dval);
            end else begin
                r.status = ST_DEADEND;
            end

            n_bytes++;
            if (r.status == ST_DONE) n_done++;
            if (r.status == ST_DEADEND) n_dead++;
            if (r.byte_count == 3'd4) n_wide++;
            due_q.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [AccW-1:0] cp, logic [CountW-1:0] cnt);
            ncr_result_t exp_r;

            if (due_q.size() == 0) begin
                $error("result with nothing expected: status %0d code %0h count %0d",
                       st, cp, cnt);
                errors++;
                return;
            end
            exp_r = due_q.pop_front();
            if (st !== exp_r.status) begin
                $error("result_status: expected %0d, got %0d", exp_r.status, st);
                errors++;
            end
            if (cp !== exp_r.code_point) begin
                $error("code_point: expected %0h, got %0h", exp_r.code_point, cp);
                errors++;
            end
            if (cnt !== exp_r.byte_count) begin
                $error("byte_count: expected %0d, got %0d", exp_r.byte_count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn         = 1'b0;
    logic              s_valid         = 1'b0;
    logic              s_ready;
    logic [ByteW-1:0]  s_in_byte       = '0;
    logic              m_valid;
    logic              m_ready         = 1'b0;
    logic [1:0]        m_result_status;
    logic [AccW-1:0]   m_code_point;
    logic [CountW-1:0] m_byte_count;

    // Idle percentages for the current phase.
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;

    ncr_scoreboard sb = new();

    numeric_char_ref_decoder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_status (m_result_status),
        .m_code_point    (m_code_point),
        .m_byte_count    (m_byte_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the handshake hangs.
    initial begin
        #5_000_000;
        $display("numeric_char_ref_decoder test failed");
        $finish;
    end

    // Present one byte, optionally after random idle cycles, and hold it until taken.
    // Returns in the time step of the accepting edge; the scoreboard is updated there.
    task automatic send_byte(input logic [ByteW-1:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(b);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i]);
    endtask

    // Result side: check each accepted item, then pick m_ready for the next cycle.
    // Values are sampled before this edge's updates land, so no ordering race.
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                sb.check_result(m_result_status, m_code_point, m_byte_count);
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin
        int unsigned kind;
        int unsigned n_digits;
        int unsigned sel;
        int unsigned target;
        bit          hex;
        bit          extreme;
        logic [ByteW-1:0] ch;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, no idling: byte extremes in idle, semicolon in idle,
        // empty hex reference, 'x' in both active modes, bad letters in both
        // modes, both letter cases in hex, leading zero in decimal.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text(";");
        send_text("x;");
        send_text("xx");
        send_text("1x");
        send_text("5A");
        send_text("xaF;");
        send_text("x1G");
        send_text("09;");

        // Random part in four phases: steady flow, sender gaps, receiver stalls, both.
        target = sb.n_bytes;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
                default: begin src_idle_pct = 8; sink_stall_pct = 8; end
            endcase
            target += 213;
            while (sb.n_bytes < target) begin
                kind = $urandom_range(99);
                if (kind < 15) begin
                    // noise byte, any value
                    send_byte(ByteW'($urandom_range(255)));
                end else begin
                    // well-formed reference, or one broken off by a random byte
                    hex      = $urandom_range(1);
                    extreme  = ($urandom_range(3) == 0);
                    n_digits = $urandom_range(hex ? 10 : 12);
                    if (hex)
                        send_byte(ChLowX);
                    else
                        send_byte(extreme ? ChNine : ByteW'(ChZero + $urandom_range(9)));
                    repeat (n_digits) begin
                        if (!hex) begin
                            ch = extreme ? ChNine : ByteW'(ChZero + $urandom_range(9));
                        end else if (extreme) begin
                            // all-F runs reach the top code points and overflow
                            ch = $urandom_range(1) ? ChUpF : ChLowF;
                        end else begin
                            sel = $urandom_range(21);
                            if (sel < 10)      ch = ByteW'(ChZero + sel);
                            else if (sel < 16) ch = ByteW'(ChUpA + sel - 10);
                            else               ch = ByteW'(ChLowA + sel - 16);
                        end
                        send_byte(ch);
                    end
                    if (kind < 85)
                        send_byte(ChSemi);
                    else
                        send_byte(ByteW'($urandom_range(255)));
                end
            end
        end

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        // keep running so a stray extra result would still be caught
        repeat (20) @(posedge aclk);

        $display("Sent %0d bytes over four idle/stall phases: %0d references completed",
                 sb.n_bytes, sb.n_done);
        $display("(%0d four-byte code points), %0d dead ends", sb.n_wide, sb.n_dead);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("numeric_char_ref_decoder test passed");
        else
            $display("numeric_char_ref_decoder test failed");
        $finish;
    end

endmodule

/* numeric_char_ref_decoder.f */
rtl/core/ncr_pkg.sv
rtl/core/ncr_classify.sv
rtl/core/ncr_parse.sv
rtl/core/numeric_char_ref_decoder.sv
rtl/core/ncr_checker.sv
sim/tb_numeric_char_ref_decoder.sv
